[design/lpc_pkg.sv]
package lpc_pkg;

  localparam int LABEL_W = 5;
  localparam int WINNER_W = 7;
  localparam int MAX_COORDS = 5;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               last;
  } lpc_in_t;

  typedef struct packed {
    logic [LABEL_W-1:0]  canonical_label;
    logic                last_out;
    logic [WINNER_W-1:0] winner_index;
  } lpc_out_t;

  function automatic int factorial(int n);
    int f;
    f = 1;
    for (int k = 2; k <= n; k++) begin
      f = f * k;
    end
    return f;
  endfunction

  // Source coordinate that lands on coordinate b under permutation number p,
  // with permutations of n coordinates numbered in lexicographic order.
  function automatic int perm_src(int n, int p, int b);
    int a [MAX_COORDS];
    int i;
    int j;
    int t;
    int src;
    for (int k = 0; k < MAX_COORDS; k++) begin
      a[k] = k;
    end
    for (int k = 0; k < p; k++) begin
      i = n - 2;
      while (i >= 0 && a[i] >= a[i + 1]) begin
        i--;
      end
      if (i >= 0) begin
        j = n - 1;
        while (a[j] <= a[i]) begin
          j--;
        end
        t = a[i];
        a[i] = a[j];
        a[j] = t;
        j = n - 1;
        i = i + 1;
        while (i < j) begin
          t = a[i];
          a[i] = a[j];
          a[j] = t;
          i++;
          j--;
        end
      end
    end
    src = 0;
    for (int k = 0; k < n; k++) begin
      if (a[k] == b) begin
        src = k;
      end
    end
    return src;
  endfunction

endpackage

[design/lpc_select.sv]
module lpc_select import lpc_pkg::*; #(
  parameter int COORDS = 5,
  parameter int PERMS = 120
) (
  input  logic [LABEL_W-1:0] label_i,
  input  logic [PERMS-1:0]   mask_i,
  output logic [LABEL_W-1:0] best_o,
  output logic [PERMS-1:0]   survivors_o
);

  logic [PERMS-1:0] col [COORDS];

  for (genvar b = 0; b < COORDS; b++) begin : g_bit
    for (genvar p = 0; p < PERMS; p++) begin : g_perm
      localparam int Src = perm_src(COORDS, p, b);
      assign col[b][p] = label_i[Src];
    end
  end

  // The least value is found one bit at a time from the top, keeping only
  // the permutations that agree with the prefix chosen so far.
  always_comb begin
    logic [PERMS-1:0] cand;
    logic [PERMS-1:0] zero;
    cand = mask_i;
    zero = '0;
    best_o = label_i;
    for (int b = COORDS - 1; b >= 0; b--) begin
      zero = cand & ~col[b];
      if (|zero) begin
        cand = zero;
        best_o[b] = 1'b0;
      end else begin
        best_o[b] = 1'b1;
      end
    end
    survivors_o = cand;
  end

endmodule

[design/lpc_first_set.sv]
module lpc_first_set import lpc_pkg::*; #(
  parameter int PERMS = 120
) (
  input  logic [PERMS-1:0]    vec_i,
  output logic [WINNER_W-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = PERMS - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = WINNER_W'(i);
      end
    end
  end

endmodule

[design/label_permutation_canonicalizer_unit.sv]
// An accepted beat moves from the input to the output register when the output
// stage is free. Throughput: one beat per cycle while out_stall_i is low; a
// result in the output register does not keep a beat out of the input register.
// The survivor mask is updated as a beat passes from input to output stage.
// Reset clears both stage valid flags and sets every bit of the mask.
module label_permutation_canonicalizer_unit import lpc_pkg::*; #(
  parameter int COORDS = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lpc_in_t  in_beat_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lpc_out_t out_beat_o
);

  localparam int Perms = factorial(COORDS);

  logic                s1_valid_q;
  logic                s1_valid_d;
  lpc_in_t             s1_beat_q;
  logic                out_valid_q;
  logic                out_valid_d;
  lpc_out_t            out_beat_q;
  lpc_out_t            out_beat_d;
  logic [Perms-1:0]    mask_q;
  logic [Perms-1:0]    mask_d;
  logic                s2_free;
  logic                s1_move;
  logic                in_take;
  logic [LABEL_W-1:0]  best;
  logic [Perms-1:0]    survivors;
  logic [WINNER_W-1:0] winner;

  lpc_select #(
    .COORDS(COORDS),
    .PERMS (Perms)
  ) u_select (
    .label_i    (s1_beat_q.label),
    .mask_i     (mask_q),
    .best_o     (best),
    .survivors_o(survivors)
  );

  lpc_first_set #(
    .PERMS(Perms)
  ) u_first_set (
    .vec_i(survivors),
    .idx_o(winner)
  );

  assign s2_free    = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
    out_valid_d = s1_move ? 1'b1 : (s2_free ? 1'b0 : out_valid_q);
    out_beat_d.canonical_label = best;
    out_beat_d.last_out        = s1_beat_q.last;
    out_beat_d.winner_index    = s1_beat_q.last ? winner : '0;
    mask_d = mask_q;
    if (s1_move) begin
      mask_d = s1_beat_q.last ? '1 : survivors;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= '1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_beat_q <= in_beat_i;
    end
    if (s1_move) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule
